// ===== sv/tcw_pkg.sv =====
// shared constants for the text console writer
package tcw_pkg;

	// default screen geometry
	localparam int TCW_COLUMNS = 80;
	localparam int TCW_ROWS    = 25;

	// field widths of the request and response transfers
	localparam int REQ_W   = 2;
	localparam int CHAR_W  = 8;
	localparam int ROW_W   = 5;
	localparam int COL_W   = 7;
	localparam int COLOR_W = 8;
	localparam int CELL_W  = CHAR_W + COLOR_W;

	// request codes
	localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	// character codes with special handling
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

	// color after reset: light grey on black
	localparam logic [COLOR_W-1:0] COLOR_RESET = 8'd7;

endpackage

// ===== sv/tcw_screen_mem.sv =====
// screen store: one write port, one registered read port
module tcw_screen_mem #(
	parameter  int DEPTH  = tcw_pkg::TCW_COLUMNS * tcw_pkg::TCW_ROWS,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [ADDR_W-1:0]          wr_addr,
	input  logic [tcw_pkg::CELL_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [ADDR_W-1:0]          rd_addr,
	output logic [tcw_pkg::CELL_W-1:0] rd_data
);
	import tcw_pkg::*;

	logic [CELL_W-1:0] mem [DEPTH];
	logic [CELL_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/text_console_writer.sv =====
// text console writer: cursor sequencer around the screen store
// clear and put with scroll walk the screen store one entry per cycle
// throughput: one request at a time; the next request transfer is taken once the
//   sequencer is back in idle, which it enters as the response is loaded
// reset: cursor homed, color 7, no response pending; store contents undefined
//   until the first clear request
module text_console_writer #(
	parameter int COLUMNS = tcw_pkg::TCW_COLUMNS,
	parameter int ROWS    = tcw_pkg::TCW_ROWS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        cfg_write,
	input  logic [tcw_pkg::COLOR_W-1:0] cfg_data,
	// request channel
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [tcw_pkg::REQ_W-1:0]   req_type,
	input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
	input  logic [tcw_pkg::ROW_W-1:0]   read_row,
	input  logic [tcw_pkg::COL_W-1:0]   read_col,
	// response channel
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [tcw_pkg::CELL_W-1:0]  cell_entry,
	output logic [tcw_pkg::ROW_W-1:0]   cursor_row,
	output logic [tcw_pkg::COL_W-1:0]   cursor_col,
	output logic                        scrolled
);
	import tcw_pkg::*;

	localparam int TOTAL  = ROWS * COLUMNS;
	localparam int MOVE_N = (ROWS - 1) * COLUMNS;
	localparam int ADDR_W = $clog2(TOTAL);
	localparam int CNT_W  = $clog2(TOTAL + 1);
	localparam int RW     = $clog2(ROWS);
	localparam int CW     = $clog2(COLUMNS);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_RWAIT  = 6'b000100,
		S_SCROLL = 6'b001000,
		S_FILL   = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t              state_q;
	logic [COLOR_W-1:0]  color_q;
	logic [RW-1:0]       cur_row_q;
	logic [CW-1:0]       cur_col_q;
	logic [REQ_W-1:0]    req_type_q;
	logic [CHAR_W-1:0]   char_q;
	logic [ROW_W-1:0]    rrow_q;
	logic [COL_W-1:0]    rcol_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                mv_valid_s1;
	logic [ADDR_W-1:0]   mv_addr_s1;
	logic [CELL_W-1:0]   cell_q;
	logic                scroll_q;
	logic                rsp_valid_q;
	logic [CELL_W-1:0]   cell_entry_q;
	logic [ROW_W-1:0]    cursor_row_q;
	logic [COL_W-1:0]    cursor_col_q;
	logic                scrolled_q;

	logic                req_xfer;
	logic                rsp_free;
	logic                is_read;
	logic                read_in_range;
	logic [7:0]          row_sel;
	logic [7:0]          col_sel;
	logic [ADDR_W-1:0]   cell_addr;
	logic [CNT_W-1:0]    src_cnt;
	logic [CELL_W-1:0]   blank_cell;
	logic                on_bottom_row;
	logic                last_col;
	logic                wr_en;
	logic [ADDR_W-1:0]   wr_addr;
	logic [CELL_W-1:0]   wr_data;
	logic                rd_en;
	logic [ADDR_W-1:0]   rd_addr;
	logic [CELL_W-1:0]   rd_data;
	logic [RW+ROW_W-1:0] row_ext;
	logic [CW+COL_W-1:0] col_ext;

	assign req_stall = (state_q != S_IDLE);
	assign req_xfer  = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// shared address unit: row times width plus column
	assign is_read       = (req_type_q == REQ_READ);
	assign read_in_range = (32'(rrow_q) < 32'(ROWS)) && (32'(rcol_q) < 32'(COLUMNS));
	assign row_sel       = is_read ? 8'(rrow_q) : 8'(cur_row_q);
	assign col_sel       = is_read ? 8'(rcol_q) : 8'(cur_col_q);
	assign cell_addr     = ADDR_W'(32'(row_sel) * COLUMNS + 32'(col_sel));

	// source of the row move is one row below the destination
	assign src_cnt       = cnt_q + CNT_W'(COLUMNS);
	assign blank_cell    = {color_q, CH_SPACE};
	assign on_bottom_row = (cur_row_q == RW'(ROWS - 1));
	assign last_col      = (cur_col_q == CW'(COLUMNS - 1));

	// store port selection
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cell_addr;
		wr_data = {color_q, char_q};
		rd_en   = 1'b0;
		rd_addr = cell_addr;
		unique case (state_q)
			S_DECODE: begin
				if (req_type_q == REQ_PUT && char_q != CH_NEWLINE && char_q != CH_RETURN) begin
					wr_en = 1'b1;
				end
				if (is_read && read_in_range) begin
					rd_en = 1'b1;
				end
			end
			S_SCROLL: begin
				wr_en   = mv_valid_s1;
				wr_addr = mv_addr_s1;
				wr_data = rd_data;
				rd_en   = (cnt_q < CNT_W'(MOVE_N));
				rd_addr = src_cnt[ADDR_W-1:0];
			end
			S_FILL: begin
				wr_en   = 1'b1;
				wr_addr = cnt_q[ADDR_W-1:0];
				wr_data = blank_cell;
			end
			S_IDLE, S_RWAIT, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	tcw_screen_mem #(
		.DEPTH(TOTAL)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= COLOR_RESET;
		end else if (cfg_write) begin
			color_q <= cfg_data;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			req_type_q <= req_type;
			char_q     <= char_code;
			rrow_q     <= read_row;
			rcol_q     <= read_col;
		end
	end

	// sequencer, cursor and walk counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			cnt_q       <= '0;
			mv_valid_s1 <= 1'b0;
			scroll_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_xfer) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					scroll_q <= 1'b0;
					cnt_q    <= '0;
					state_q  <= S_DONE;
					case (req_type_q)
						REQ_PUT: begin
							if (char_q == CH_RETURN) begin
								cur_col_q <= '0;
							end else if (char_q == CH_NEWLINE || last_col) begin
								cur_col_q <= '0;
								if (on_bottom_row) begin
									scroll_q <= 1'b1;
									state_q  <= S_SCROLL;
								end else begin
									cur_row_q <= cur_row_q + 1'b1;
								end
							end else begin
								cur_col_q <= cur_col_q + 1'b1;
							end
						end
						REQ_READ: begin
							if (read_in_range) begin
								state_q <= S_RWAIT;
							end
						end
						REQ_CLEAR: begin
							cur_row_q <= '0;
							cur_col_q <= '0;
							state_q   <= S_FILL;
						end
						default: begin
						end
					endcase
				end
				S_RWAIT: begin
					state_q <= S_DONE;
				end
				S_SCROLL: begin
					// read one row down, write back in the following cycle
					mv_valid_s1 <= (cnt_q < CNT_W'(MOVE_N));
					if (cnt_q == CNT_W'(MOVE_N)) begin
						state_q <= S_FILL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FILL: begin
					if (cnt_q == CNT_W'(TOTAL - 1)) begin
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// move stage destination address
	always_ff @(posedge clk) begin
		mv_addr_s1 <= cnt_q[ADDR_W-1:0];
	end

	// read data for the response
	always_ff @(posedge clk) begin
		if (state_q == S_DECODE) begin
			cell_q <= '0;
		end else if (state_q == S_RWAIT) begin
			cell_q <= rd_data;
		end
	end

	assign row_ext = {{ROW_W{1'b0}}, cur_row_q};
	assign col_ext = {{COL_W{1'b0}}, cur_col_q};

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && rsp_free) begin
			cell_entry_q <= cell_q;
			cursor_row_q <= row_ext[ROW_W-1:0];
			cursor_col_q <= col_ext[COL_W-1:0];
			scrolled_q   <= scroll_q;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign cell_entry = cell_entry_q;
	assign cursor_row = cursor_row_q;
	assign cursor_col = cursor_col_q;
	assign scrolled   = scrolled_q;

	// cursor stays on the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(cur_row_q) < 32'(ROWS)) && (32'(cur_col_q) < 32'(COLUMNS)))
		else $error("cursor off screen");

	// a scroll leaves the cursor at the start of the bottom row
	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && scroll_q) |-> (on_bottom_row && cur_col_q == '0))
		else $error("cursor wrong after scroll");

	// row move writes only happen during the scroll walk
	a_move_in_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		mv_valid_s1 |-> (state_q == S_SCROLL))
		else $error("row move write outside scroll");

	// a response is only loaded from the done state
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_DONE))
		else $error("response loaded outside done");

	// a request transfer always starts decode
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer |=> (state_q == S_DECODE))
		else $error("accepted request not decoded");

endmodule

// ===== bench/testbench.sv =====
// testbench for the text console writer: directed and random requests checked against a shadow console
module testbench;
	import tcw_pkg::*;

	localparam int SCREEN_CELLS = TCW_ROWS * TCW_COLUMNS;
	localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;
	localparam int ITEM_GOAL = 1550;
	localparam int PHASES = 6;
	localparam int CYCLE_LIMIT = 4 * (ITEM_GOAL + 600) * (SCREEN_CELLS + 20);
	localparam int SHOWN_MISMATCHES = 10;

	typedef struct packed {
		logic [REQ_W-1:0]  kind;
		logic [CHAR_W-1:0] ch;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
	} console_req_t;

	typedef struct packed {
		logic [CELL_W-1:0] entry;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic              scrolled;
	} console_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [COLOR_W-1:0] cfg_data = COLOR_RESET;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [REQ_W-1:0] req_type = REQ_PUT;
	logic [CHAR_W-1:0] char_code = '0;
	logic [ROW_W-1:0] read_row = '0;
	logic [COL_W-1:0] read_col = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [CELL_W-1:0] cell_entry;
	logic [ROW_W-1:0] cursor_row;
	logic [COL_W-1:0] cursor_col;
	logic scrolled;

	// shadow of the console state
	logic [CELL_W-1:0] shadow_screen [SCREEN_CELLS];
	int cur_row = 0;
	int cur_col = 0;
	logic [COLOR_W-1:0] text_color = COLOR_RESET;

	console_req_t req_q[$];
	console_report_t report_q[$];
	console_req_t next_req;
	console_report_t got_report;
	console_report_t want_report;

	logic req_fire = 1'b0;
	logic rsp_fire = 1'b0;
	bit req_calm = 1'b0;
	bit rsp_calm = 1'b0;
	int req_gap = 0;
	int rsp_wait = 0;
	int issued = 0;
	int replies = 0;
	int scroll_count = 0;
	int color_writes = 0;
	int mismatches = 0;
	int cycles = 0;

	text_console_writer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.char_code(char_code),
		.read_row(read_row),
		.read_col(read_col),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.cell_entry(cell_entry),
		.cursor_row(cursor_row),
		.cursor_col(cursor_col),
		.scrolled(scrolled)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// move to the next line, scrolling the screen past the bottom row
	function automatic bit line_feed();
		int i;
		cur_col = 0;
		cur_row++;
		if (cur_row < TCW_ROWS)
			return 1'b0;
		for (i = 0; i < SCREEN_CELLS - TCW_COLUMNS; i++)
			shadow_screen[i] = shadow_screen[i + TCW_COLUMNS];
		for (i = SCREEN_CELLS - TCW_COLUMNS; i < SCREEN_CELLS; i++)
			shadow_screen[i] = {text_color, CH_SPACE};
		cur_row = TCW_ROWS - 1;
		return 1'b1;
	endfunction

	// apply one request to the shadow console and queue the reply it should give
	task automatic advance_console(input console_req_t r);
		console_report_t rep;
		int i;
		rep = '0;
		case (r.kind)
			REQ_PUT: begin
				if (r.ch == CH_NEWLINE) begin
					rep.scrolled = line_feed();
				end else if (r.ch == CH_RETURN) begin
					cur_col = 0;
				end else begin
					shadow_screen[cur_row * TCW_COLUMNS + cur_col] = {text_color, r.ch};
					cur_col++;
					if (cur_col >= TCW_COLUMNS)
						rep.scrolled = line_feed();
				end
			end
			REQ_READ: begin
				if (r.row < TCW_ROWS && r.col < TCW_COLUMNS)
					rep.entry = shadow_screen[r.row * TCW_COLUMNS + r.col];
			end
			REQ_CLEAR: begin
				for (i = 0; i < SCREEN_CELLS; i++)
					shadow_screen[i] = {text_color, CH_SPACE};
				cur_row = 0;
				cur_col = 0;
			end
			default: ;
		endcase
		rep.row = cur_row[ROW_W-1:0];
		rep.col = cur_col[COL_W-1:0];
		report_q.push_back(rep);
	endtask

	function automatic int draw_pause(input bit calm);
		return calm ? 0 : int'($urandom_range(0, 6));
	endfunction

	// request driver
	always @(negedge clk) begin
		if (!req_valid || req_fire) begin
			if (req_gap > 0) begin
				req_valid <= 1'b0;
				req_gap--;
			end else if (req_q.size() > 0) begin
				next_req = req_q.pop_front();
				req_type <= next_req.kind;
				char_code <= next_req.ch;
				read_row <= next_req.row;
				read_col <= next_req.col;
				req_valid <= 1'b1;
				if ($urandom_range(0, 31) == 0)
					req_calm = !req_calm;
				req_gap = draw_pause(req_calm);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// request monitor: every accepted transfer updates the shadow console
	always @(posedge clk) begin
		req_fire <= arst_n && req_valid && !req_stall;
		if (arst_n && req_valid && !req_stall)
			advance_console({req_type, char_code, read_row, read_col});
	end

	// response stall generator
	always @(negedge clk) begin
		if (rsp_fire) begin
			if ($urandom_range(0, 31) == 0)
				rsp_calm = !rsp_calm;
			rsp_wait = draw_pause(rsp_calm);
		end
		if (rsp_wait > 0) begin
			rsp_stall <= 1'b1;
			rsp_wait--;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// response monitor: compare each reply with the oldest pending one
	always @(posedge clk) begin
		rsp_fire <= arst_n && rsp_valid && !rsp_stall;
		if (arst_n && rsp_valid && !rsp_stall) begin
			got_report = {cell_entry, cursor_row, cursor_col, scrolled};
			replies++;
			if (scrolled === 1'b1)
				scroll_count++;
			if (report_q.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES)
					$display("unexpected reply %0d: entry %h row %0d col %0d scrolled %0d",
						replies, cell_entry, cursor_row, cursor_col, scrolled);
			end else begin
				want_report = report_q.pop_front();
				if (got_report !== want_report) begin
					mismatches++;
					if (mismatches <= SHOWN_MISMATCHES)
						$display("reply %0d: expected entry %h row %0d col %0d scrolled %0d, %s %h row %0d col %0d scrolled %0d",
							replies, want_report.entry, want_report.row, want_report.col,
							want_report.scrolled, "got entry", cell_entry, cursor_row,
							cursor_col, scrolled);
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic queue_req(input logic [REQ_W-1:0] kind, input logic [CHAR_W-1:0] ch,
			input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
		req_q.push_back({kind, ch, row, col});
		issued++;
	endtask

	// put with random unused fields
	task automatic queue_put(input logic [CHAR_W-1:0] ch);
		queue_req(REQ_PUT, ch, ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
	endtask

	task automatic queue_read(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
		queue_req(REQ_READ, CHAR_W'($urandom_range(0, 255)), row, col);
	endtask

	// one burst of random traffic, mostly text runs with line control
	task automatic add_burst();
		int pick;
		int k;
		pick = $urandom_range(0, 19);
		if (pick < 9) begin
			repeat ($urandom_range(1, 60))
				queue_put(CHAR_W'($urandom_range(0, 255)));
			k = $urandom_range(0, 3);
			if (k < 2)
				queue_put(CH_NEWLINE);
			else if (k == 2)
				queue_put(CH_RETURN);
		end else if (pick < 11) begin
			repeat ($urandom_range(1, 4))
				queue_put(CH_NEWLINE);
		end else if (pick < 16) begin
			repeat ($urandom_range(1, 6)) begin
				if ($urandom_range(0, 7) == 0)
					queue_read(ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
				else
					queue_read(ROW_W'($urandom_range(0, TCW_ROWS - 1)),
						COL_W'($urandom_range(0, TCW_COLUMNS - 1)));
			end
		end else if (pick < 18) begin
			repeat ($urandom_range(1, 3))
				queue_req(REQ_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
					ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
		end else if (pick == 18) begin
			// full line, crosses the last column
			if ($urandom_range(0, 1) == 1)
				queue_put(CH_RETURN);
			repeat ($urandom_range(TCW_COLUMNS - 1, TCW_COLUMNS + 1))
				queue_put(CHAR_W'($urandom_range(32, 126)));
		end else begin
			queue_req(REQ_CLEAR, CHAR_W'($urandom_range(0, 255)), ROW_W'($urandom_range(0, 31)),
				COL_W'($urandom_range(0, 127)));
		end
	endtask

	// wait until every request is sent and every reply is back
	task automatic wait_idle();
		while (req_q.size() != 0 || req_valid || report_q.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_text_color(input logic [COLOR_W-1:0] c);
		@(negedge clk);
		cfg_data <= c;
		cfg_write <= 1'b1;
		@(negedge clk);
		cfg_write <= 1'b0;
		text_color = c;
		color_writes++;
	endtask

	// stimulus and end of run
	initial begin
		logic [COLOR_W-1:0] phase_color [PHASES];
		int p;
		int target;
		int i;

		for (i = 0; i < SCREEN_CELLS; i++)
			shadow_screen[i] = '0;
		phase_color[0] = 8'h00;
		phase_color[1] = 8'hFF;
		phase_color[2] = COLOR_W'($urandom_range(0, 255));
		phase_color[3] = 8'h5A;
		phase_color[4] = 8'hA5;
		phase_color[5] = COLOR_RESET;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: only the cell written by the first put is read before the first clear
		queue_req(REQ_PUT, 8'h48, 5'd31, 7'd127);
		queue_req(REQ_READ, 8'hFF, 5'd0, 7'd0);
		queue_req(REQ_READ, 8'h00, 5'd31, 7'd127);
		queue_req(REQ_NONE, 8'hFF, 5'd31, 7'd127);
		queue_req(REQ_CLEAR, 8'hFF, 5'd31, 7'd127);
		queue_req(REQ_READ, 8'h00, 5'd24, 7'd79);
		queue_req(REQ_PUT, 8'h00, 5'd0, 7'd0);
		queue_req(REQ_PUT, 8'hFF, 5'd0, 7'd0);
		queue_req(REQ_PUT, CH_RETURN, 5'd31, 7'd127);
		queue_req(REQ_PUT, 8'h78, 5'd0, 7'd0);
		queue_req(REQ_PUT, CH_NEWLINE, 5'd31, 7'd127);
		queue_req(REQ_PUT, CH_RETURN, 5'd0, 7'd0);
		queue_req(REQ_READ, 8'h00, 5'd0, 7'd0);
		queue_req(REQ_READ, 8'h00, 5'd0, 7'd1);
		queue_req(REQ_READ, 8'h00, 5'd25, 7'd0);
		queue_req(REQ_READ, 8'h00, 5'd0, 7'd80);
		queue_req(REQ_READ, 8'h00, 5'd24, 7'd127);
		queue_req(REQ_NONE, 8'h00, 5'd0, 7'd0);
		queue_req(REQ_PUT, CH_NEWLINE, 5'd0, 7'd0);
		queue_req(REQ_CLEAR, 8'h00, 5'd0, 7'd0);
		wait_idle();

		// random phases, one text color each
		for (p = 0; p < PHASES; p++) begin
			set_text_color(phase_color[p]);
			target = issued + ITEM_GOAL / PHASES;
			while (issued < target)
				add_burst();
			wait_idle();
		end

		repeat (SCREEN_CELLS + 8) @(posedge clk);
		$display("sent %0d requests under %0d text colors after the reset color",
			issued, color_writes);
		$display("checked %0d replies, %0d of them with a screen scroll", replies, scroll_count);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
